// ----- rtl/core/ilss_pkg.sv -----
package ilss_pkg;

   localparam logic [2:0] OP_APPEND = 3'd0;
   localparam logic [2:0] OP_INSERT = 3'd1;
   localparam logic [2:0] OP_DELETE = 3'd2;
   localparam logic [2:0] OP_EDIT   = 3'd3;
   localparam logic [2:0] OP_READ   = 3'd4;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_BOUNDS = 2'd1;
   localparam logic [1:0] STATUS_EMPTY  = 2'd2;
   localparam logic [1:0] STATUS_FULL   = 2'd3;

   localparam logic [31:0] READ_ERROR     = 32'hFFFF_FFFF;
   localparam logic [6:0]  INIT_CAP_RESET = 7'd8;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT,
      S_PLACE,
      S_READ,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] read_value;
      logic [6:0]         element_count;
      logic [6:0]         current_capacity;
   } rsp_type;

endpackage

// ----- rtl/core/ilss_mem.sv -----
module ilss_mem
   import ilss_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/ilss_ctrl.sv -----
module ilss_ctrl
   import ilss_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int CW    = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [2:0]    req_opcode,
   input  logic [5:0]    req_position,
   input  logic [31:0]   req_item_value,
   input  logic          csr_wr_en,
   input  logic [6:0]    csr_wr_data,
   output logic          res_valid,
   input  logic          res_stall,
   output rsp_type       res,
   output logic          mem_wr_en,
   output logic [AW-1:0] mem_wr_addr,
   output logic [31:0]   mem_wr_data,
   output logic          mem_rd_en,
   output logic [AW-1:0] mem_rd_addr,
   input  logic [31:0]   mem_rd_data
);

   localparam int XW = (CW > 7) ? CW : 7;

   function automatic logic [CW-1:0] clamp_cap(input logic [6:0] v);
      logic [CW-1:0] r;
      if (v == 7'd0) begin
         r = CW'(1);
      end else if (XW'(v) > XW'(DEPTH)) begin
         r = CW'(DEPTH);
      end else begin
         r = CW'(v);
      end
      return r;
   endfunction

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] cap_ff, cap_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [AW-1:0] last_ff, last_in;
   logic          dir_up_ff, dir_up_in;
   logic [31:0]   val_ff, val_in;
   logic [1:0]    status_ff, status_in;
   logic [31:0]   rd_ff, rd_in;

   logic          accept;
   logic [XW-1:0] pos_x, cnt_x, cap_x;
   logic [AW-1:0] pos_a, cnt_a;
   logic          has_room, at_depth;
   logic [CW:0]   cap_dbl;
   logic [CW-1:0] cap_grow, cap_half, count_dec;
   logic          shift_done;

   logic [1:0]    dec_status;
   logic [31:0]   dec_rd;
   logic          dec_wr, dec_rd_en, dec_shift, dec_read, dec_up;
   logic          dec_grow, dec_inc, dec_dec, dec_shrink;
   logic [AW-1:0] dec_wr_addr, dec_rd_addr, dec_last;

   assign accept     = req_valid && (state_ff == S_IDLE);
   assign pos_x      = XW'(req_position);
   assign cnt_x      = XW'(count_ff);
   assign cap_x      = XW'(cap_ff);
   assign pos_a      = AW'(req_position);
   assign cnt_a      = AW'(count_ff);
   assign has_room   = count_ff < cap_ff;
   assign at_depth   = cap_ff == CW'(DEPTH);
   assign cap_dbl    = {cap_ff, 1'b0};
   assign cap_grow   = (cap_dbl > (CW + 1)'(DEPTH)) ? CW'(DEPTH) : cap_dbl[CW-1:0];
   assign cap_half   = cap_ff >> 1;
   assign count_dec  = count_ff - CW'(1);
   assign shift_done = addr_ff == last_ff;

   always_comb begin
      dec_status  = STATUS_OK;
      dec_rd      = 32'd0;
      dec_wr      = 1'b0;
      dec_rd_en   = 1'b0;
      dec_shift   = 1'b0;
      dec_read    = 1'b0;
      dec_up      = 1'b0;
      dec_grow    = 1'b0;
      dec_inc     = 1'b0;
      dec_dec     = 1'b0;
      dec_shrink  = 1'b0;
      dec_wr_addr = cnt_a;
      dec_rd_addr = pos_a;
      dec_last    = pos_a;
      case (req_opcode)
         OP_APPEND: begin
            if (!has_room && at_depth) begin
               dec_status = STATUS_FULL;
            end else begin
               dec_grow = !has_room;
               dec_inc  = 1'b1;
               dec_wr   = 1'b1;
            end
         end
         OP_INSERT: begin
            if (pos_x >= cap_x || pos_x > cnt_x) begin
               dec_status = STATUS_BOUNDS;
            end else if (!has_room && at_depth) begin
               dec_status = STATUS_FULL;
            end else begin
               dec_grow = !has_room;
               dec_inc  = 1'b1;
               dec_up   = 1'b1;
               if (pos_x == cnt_x) begin
                  dec_wr = 1'b1;
               end else begin
                  dec_rd_en   = 1'b1;
                  dec_rd_addr = AW'(count_ff - CW'(1));
                  dec_shift   = 1'b1;
               end
            end
         end
         OP_DELETE: begin
            if (pos_x >= cnt_x) begin
               dec_status = STATUS_BOUNDS;
            end else begin
               dec_dec    = 1'b1;
               dec_shrink = (cap_ff > CW'(1)) && (count_dec < cap_half);
               dec_last   = AW'(count_dec);
               if (pos_x + XW'(1) < cnt_x) begin
                  dec_rd_en   = 1'b1;
                  dec_rd_addr = pos_a + AW'(1);
                  dec_shift   = 1'b1;
               end
            end
         end
         OP_EDIT: begin
            if (pos_x >= cnt_x) begin
               dec_status = STATUS_BOUNDS;
            end else begin
               dec_wr      = 1'b1;
               dec_wr_addr = pos_a;
            end
         end
         OP_READ: begin
            if (count_ff == CW'(0)) begin
               dec_status = STATUS_EMPTY;
               dec_rd     = READ_ERROR;
            end else if (pos_x >= cnt_x) begin
               dec_status = STATUS_BOUNDS;
               dec_rd     = READ_ERROR;
            end else begin
               dec_rd_en = 1'b1;
               dec_read  = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (dec_shift) begin
                  state_in = S_SHIFT;
               end else if (dec_read) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SHIFT: begin
            if (shift_done) begin
               state_in = dir_up_ff ? S_PLACE : S_DONE;
            end
         end
         S_PLACE: begin
            state_in = S_DONE;
         end
         S_READ: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!res_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      res_valid   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = dec_wr_addr;
      mem_wr_data = req_item_value;
      mem_rd_en   = 1'b0;
      mem_rd_addr = dec_rd_addr;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            mem_wr_en = accept && dec_wr;
            mem_rd_en = accept && dec_rd_en;
         end
         S_SHIFT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = dir_up_ff ? addr_ff + AW'(1) : addr_ff - AW'(1);
            mem_wr_data = mem_rd_data;
            mem_rd_en   = !shift_done;
            mem_rd_addr = dir_up_ff ? addr_ff - AW'(1) : addr_ff + AW'(1);
         end
         S_PLACE: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = last_ff;
            mem_wr_data = val_ff;
         end
         S_DONE: begin
            res_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      count_in  = count_ff;
      cap_in    = cap_ff;
      addr_in   = addr_ff;
      last_in   = last_ff;
      dir_up_in = dir_up_ff;
      val_in    = val_ff;
      status_in = status_ff;
      rd_in     = rd_ff;
      if (csr_wr_en) begin
         count_in = CW'(0);
         cap_in   = clamp_cap(csr_wr_data);
      end else if (accept) begin
         status_in = dec_status;
         rd_in     = dec_rd;
         addr_in   = dec_rd_addr;
         last_in   = dec_last;
         dir_up_in = dec_up;
         val_in    = req_item_value;
         if (dec_grow) begin
            cap_in = cap_grow;
         end else if (dec_shrink) begin
            cap_in = cap_half;
         end
         if (dec_inc) begin
            count_in = count_ff + CW'(1);
         end else if (dec_dec) begin
            count_in = count_dec;
         end
      end else if (state_ff == S_SHIFT) begin
         addr_in = mem_rd_addr;
      end else if (state_ff == S_READ) begin
         rd_in = mem_rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= CW'(0);
         cap_ff   <= clamp_cap(INIT_CAP_RESET);
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         cap_ff   <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      last_ff   <= last_in;
      dir_up_ff <= dir_up_in;
      val_ff    <= val_in;
      status_ff <= status_in;
      rd_ff     <= rd_in;
   end

   assign res.status           = status_ff;
   assign res.read_value       = rd_ff;
   assign res.element_count    = 7'(count_ff);
   assign res.current_capacity = 7'(cap_ff);

endmodule

// ----- rtl/core/indexed_list_shift_store.sv -----
// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    opcode, position, item_value
// rsp_      out        rsp_valid/stall    status, read_value, element_count, current_capacity
// csr_      in         csr_wr_en          initial_capacity (write only)
//
// Append, edit, unused opcodes and refused beats go straight to the done state, a read via
// the read state. Inserts below the count and deletes below the last entry shift the entries
// through the memory's single read and write port, and an insert then places its item.
// Reset clears the count and loads the capacity; the memory is not cleared.
// The input stalls from acceptance until the result has moved into the output register.
// A stalled output register holds the finished result in the core and keeps the input stalled.
module indexed_list_shift_store
   import ilss_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_opcode,
   input  logic [5:0]         req_position,
   input  logic signed [31:0] req_item_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_read_value,
   output logic [6:0]         rsp_element_count,
   output logic [6:0]         rsp_current_capacity,
   input  logic               csr_wr_en,
   input  logic [6:0]         csr_wr_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic          res_valid, res_stall;
   rsp_type       res;
   logic          mem_wr_en, mem_rd_en;
   logic [AW-1:0] mem_wr_addr, mem_rd_addr;
   logic [31:0]   mem_wr_data, mem_rd_data;

   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;
   logic          load;

   ilss_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_position   (req_position),
      .req_item_value (req_item_value),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .res_valid      (res_valid),
      .res_stall      (res_stall),
      .res            (res),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .mem_rd_en      (mem_rd_en),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_data    (mem_rd_data)
   );

   ilss_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign res_stall = rsp_valid_ff && rsp_stall;
   assign load      = res_valid && !res_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_ff.status;
   assign rsp_read_value       = rsp_ff.read_value;
   assign rsp_element_count    = rsp_ff.element_count;
   assign rsp_current_capacity = rsp_ff.current_capacity;

endmodule
